// ----- hdl/dma_channel_sequencer_defines.svh -----
// Assertion macros shared by the DMA channel sequencer RTL.
`ifndef DMA_CHANNEL_SEQUENCER_DEFINES_SVH
`define DMA_CHANNEL_SEQUENCER_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define DCS_ASSERT_SAME(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// The condition must hold in the cycle after the trigger.
`define DCS_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ----- hdl/dcs_pkg.sv -----
// Types and constants for the DMA channel sequencer.
package dcs_pkg;

  localparam int ADDRESS_BITS   = 21;
  localparam int CHANNEL_COUNT  = 7;
  localparam int COUNT_BITS     = 24;
  localparam int WORD_BITS      = 32;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 24;
  localparam int QUEUE_DEPTH    = 4;
  localparam int PTR_BITS       = $clog2(QUEUE_DEPTH);
  localparam int LEVEL_BITS     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] CH_GPU   = 3'd2;
  localparam logic [2:0] CH_CDROM = 3'd3;
  localparam logic [2:0] CH_OTC   = 3'd6;

  localparam logic [WORD_BITS-1:0] OTC_END = 32'h00FF_FFFF;
  localparam int END_BIT = 23;

  typedef enum logic [2:0] {
    K_READ  = 3'd0,
    K_WRITE = 3'd1,
    K_GPU   = 3'd2,
    K_DONE  = 3'd3,
    K_ERROR = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_BLOCK = 2'd1,
    PH_HDR   = 2'd2,
    PH_DATA  = 2'd3
  } phase_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_BASE_ADDRESS  = 3'd0,
    REG_WORD_COUNT    = 3'd1,
    REG_TOWARD_RAM    = 3'd2,
    REG_STEP_BACKWARD = 3'd3,
    REG_LINKED_LIST   = 3'd4,
    REG_IRQ_MASK      = 3'd5,
    REG_IRQ_MASTER    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    kind_t                   kind;
    logic [ADDRESS_BITS-1:0] addr;
    logic [WORD_BITS-1:0]    word;
    logic                    irq;
    logic                    last;
  } res_t;

endpackage

// ----- hdl/dma_channel_sequencer.sv -----
// The results of an accepted transaction are written into a registered result queue and reach the output in order.
// Throughput: one input transaction per cycle while each yields at most one result; the
// single output port and a four-entry result queue limit two-result transactions to one
// result per cycle, and in_stall rises when fewer than two queue entries are free.
// Reset is synchronous and active high: it clears registers, channel flags and the queue.
module dma_channel_sequencer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                func,
  input  logic [2:0]                          channel,
  input  logic [dcs_pkg::WORD_BITS-1:0]       word_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output dcs_pkg::kind_t                      kind,
  output logic [dcs_pkg::ADDRESS_BITS-1:0]    ram_address,
  output logic [dcs_pkg::WORD_BITS-1:0]       word_out,
  output logic                                irq,
  output logic                                last,
  input  logic                                cfg_we,
  input  logic [dcs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [dcs_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import dcs_pkg::*;
  `include "dma_channel_sequencer_defines.svh"

  // Configuration registers.
  logic [ADDRESS_BITS-1:0]  base_address;
  logic [COUNT_BITS-1:0]    word_count;
  logic                     toward_ram;
  logic                     step_backward;
  logic                     linked_list_mode;
  logic [CHANNEL_COUNT-1:0] irq_enable_mask;
  logic                     irq_master_enable;

  // Transfer state.
  phase_t                   phase, phase_next;
  logic [2:0]               active_channel, active_channel_next;
  logic [ADDRESS_BITS-1:0]  current_address, current_address_next;
  logic [COUNT_BITS-1:0]    words_left, words_left_next;
  logic [7:0]               packet_words_left, packet_words_left_next;
  logic [23:0]              list_link, list_link_next;
  logic [CHANNEL_COUNT-1:0] channel_flags, channel_flags_next;

  // Result queue.
  res_t                     queue [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]      head, tail;
  logic [LEVEL_BITS-1:0]    count, count_next;

  logic                     accept, pop;
  res_t                     res0, res1;
  logic [1:0]               nres;

  // Derived values.
  logic                     start_ok;
  logic [ADDRESS_BITS-1:0]  base_aligned, addr_adv, addr_prev, addr_plus4, hdr_addr;
  logic [COUNT_BITS-1:0]    words_dec;
  logic                     block_end;
  logic [7:0]               pk_cnt;
  logic [23:0]              pk_hdr;
  logic [2:0]               fin_ch;
  logic [CHANNEL_COUNT-1:0] fin_bit;
  logic                     fin_en;
  logic [WORD_BITS-1:0]     ram_data;
  res_t                     done_res, pkt_res;
  logic                     pair_out, done_out;

  assign accept    = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;
  assign in_stall  = count > LEVEL_BITS'(QUEUE_DEPTH - 2);
  assign out_valid = count != '0;

  assign kind        = queue[head].kind;
  assign ram_address = queue[head].addr;
  assign word_out    = queue[head].word;
  assign irq         = queue[head].irq;
  assign last        = queue[head].last;

  assign start_ok = (channel != 3'(CHANNEL_COUNT)) &&
                    !(linked_list_mode && (channel != CH_GPU || toward_ram));

  assign base_aligned = {base_address[ADDRESS_BITS-1:2], 2'b00};
  assign addr_plus4   = current_address + ADDRESS_BITS'(4);
  assign addr_prev    = current_address - ADDRESS_BITS'(4);
  assign addr_adv     = step_backward ? addr_prev : addr_plus4;
  assign words_dec    = words_left - COUNT_BITS'(1);
  assign block_end    = words_dec == '0;

  // A header read fills both fields; a data word only counts down the packet.
  assign pk_cnt   = (phase == PH_HDR) ? word_in[31:24] : packet_words_left - 8'd1;
  assign pk_hdr   = (phase == PH_HDR) ? word_in[23:0] : list_link;
  assign hdr_addr = {pk_hdr[ADDRESS_BITS-1:2], 2'b00};

  // A zero-length block finishes on its own start, so the new channel decides the flag.
  assign fin_ch  = func ? active_channel : channel;
  assign fin_bit = CHANNEL_COUNT'(1) << fin_ch;
  assign fin_en  = |(irq_enable_mask & fin_bit);

  always_comb begin
    if (active_channel == CH_OTC) begin
      ram_data = block_end ? OTC_END : WORD_BITS'(addr_prev);
    end else if (active_channel == CH_GPU || active_channel == CH_CDROM) begin
      ram_data = word_in;
    end else begin
      ram_data = '0;
    end
  end

  always_comb begin
    done_res = '{kind: K_DONE, addr: '0, word: '0, irq: fin_en && irq_master_enable,
                 last: 1'b1};
    if (pk_cnt != 8'd0) begin
      pkt_res = '{kind: K_READ, addr: addr_plus4, word: '0, irq: 1'b0, last: 1'b1};
    end else if (pk_hdr[END_BIT]) begin
      pkt_res = done_res;
    end else begin
      pkt_res = '{kind: K_READ, addr: hdr_addr, word: '0, irq: 1'b0, last: 1'b1};
    end
  end

  // Next state.
  always_comb begin
    phase_next             = phase;
    active_channel_next    = active_channel;
    current_address_next   = current_address;
    words_left_next        = words_left;
    packet_words_left_next = packet_words_left;
    list_link_next         = list_link;
    channel_flags_next     = channel_flags;
    if (accept) begin
      if (!func) begin
        phase_next = PH_IDLE;
        if (start_ok) begin
          active_channel_next  = channel;
          current_address_next = base_aligned;
          if (linked_list_mode) begin
            phase_next = PH_HDR;
          end else begin
            words_left_next = word_count;
            if (word_count == '0) begin
              if (fin_en) channel_flags_next = channel_flags | fin_bit;
            end else begin
              phase_next = PH_BLOCK;
            end
          end
        end
      end else begin
        unique case (phase)
          PH_BLOCK: begin
            words_left_next      = words_dec;
            current_address_next = addr_adv;
            if (block_end) begin
              phase_next = PH_IDLE;
              if (fin_en) channel_flags_next = channel_flags | fin_bit;
            end
          end
          PH_HDR, PH_DATA: begin
            packet_words_left_next = pk_cnt;
            list_link_next         = pk_hdr;
            if (pk_cnt != 8'd0) begin
              current_address_next = addr_plus4;
              phase_next           = PH_DATA;
            end else if (pk_hdr[END_BIT]) begin
              phase_next = PH_IDLE;
              if (fin_en) channel_flags_next = channel_flags | fin_bit;
            end else begin
              current_address_next = hdr_addr;
              phase_next           = PH_HDR;
            end
          end
          PH_IDLE: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Results of the accepted transaction.
  always_comb begin
    res0 = '0;
    res1 = '0;
    nres = 2'd0;
    if (!func) begin
      nres = 2'd1;
      if (!start_ok) begin
        res0 = '{kind: K_ERROR, addr: '0, word: '0, irq: 1'b0, last: 1'b1};
      end else if (linked_list_mode) begin
        res0 = '{kind: K_READ, addr: base_aligned, word: '0, irq: 1'b0, last: 1'b1};
      end else if (word_count == '0) begin
        res0 = done_res;
      end else if (toward_ram) begin
        nres = 2'd0;
      end else begin
        res0 = '{kind: K_READ, addr: base_aligned, word: '0, irq: 1'b0, last: 1'b1};
      end
    end else begin
      unique case (phase)
        PH_BLOCK: begin
          if (toward_ram) begin
            res0 = '{kind: K_WRITE, addr: current_address, word: ram_data, irq: 1'b0,
                     last: block_end};
            res1 = done_res;
            nres = block_end ? 2'd2 : 2'd1;
          end else begin
            if (block_end) begin
              res1 = done_res;
            end else begin
              res1 = '{kind: K_READ, addr: addr_adv, word: '0, irq: 1'b0, last: 1'b1};
            end
            if (active_channel == CH_GPU) begin
              res0 = '{kind: K_GPU, addr: '0, word: word_in, irq: 1'b0, last: 1'b0};
              nres = 2'd2;
            end else begin
              res0 = res1;
              nres = 2'd1;
            end
          end
        end
        PH_HDR: begin
          res0 = pkt_res;
          nres = 2'd1;
        end
        PH_DATA: begin
          res0 = '{kind: K_GPU, addr: '0, word: word_in, irq: 1'b0, last: 1'b0};
          res1 = pkt_res;
          nres = 2'd2;
        end
        PH_IDLE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    count_next = count + LEVEL_BITS'(accept ? nres : 2'd0) - LEVEL_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address      <= '0;
      word_count        <= '0;
      toward_ram        <= 1'b0;
      step_backward     <= 1'b0;
      linked_list_mode  <= 1'b0;
      irq_enable_mask   <= '0;
      irq_master_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_ADDRESS:  base_address      <= cfg_data[ADDRESS_BITS-1:0];
        REG_WORD_COUNT:    word_count        <= cfg_data[COUNT_BITS-1:0];
        REG_TOWARD_RAM:    toward_ram        <= cfg_data[0];
        REG_STEP_BACKWARD: step_backward     <= cfg_data[0];
        REG_LINKED_LIST:   linked_list_mode  <= cfg_data[0];
        REG_IRQ_MASK:      irq_enable_mask   <= cfg_data[CHANNEL_COUNT-1:0];
        REG_IRQ_MASTER:    irq_master_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      active_channel    <= '0;
      current_address   <= '0;
      words_left        <= '0;
      packet_words_left <= '0;
      list_link         <= '0;
      channel_flags     <= '0;
      head              <= '0;
      tail              <= '0;
      count             <= '0;
    end else begin
      phase             <= phase_next;
      active_channel    <= active_channel_next;
      current_address   <= current_address_next;
      words_left        <= words_left_next;
      packet_words_left <= packet_words_left_next;
      list_link         <= list_link_next;
      channel_flags     <= channel_flags_next;
      count             <= count_next;
      if (pop) head <= head + PTR_BITS'(1);
      if (accept) tail <= tail + PTR_BITS'(nres);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && nres != 2'd0) queue[tail] <= res0;
    if (accept && nres == 2'd2) queue[tail + PTR_BITS'(1)] <= res1;
  end

  // A block write toward RAM may itself be marked last ahead of its done result.
  assign pair_out = accept && nres == 2'd2;
  assign done_out = (accept && nres != 2'd0 && res0.kind == K_DONE) ||
                    (pair_out && res1.kind == K_DONE);

  `DCS_ASSERT_SAME(a_queue_bound, 1'b1, count <= LEVEL_BITS'(QUEUE_DEPTH), "queue overflow")
  `DCS_ASSERT_NEXT(a_pop_drains, pop && !accept, count == $past(count) - LEVEL_BITS'(1), "no drain")
  `DCS_ASSERT_SAME(a_pair_order, pair_out, res1.last && res0.kind != K_ERROR, "bad result pair")
  `DCS_ASSERT_NEXT(a_done_idles, done_out, phase == PH_IDLE, "done without return to idle")
  `DCS_ASSERT_NEXT(a_flags_sticky, !rst, (~channel_flags & $past(channel_flags)) == '0, "flag lost")

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the DMA channel sequencer: block and linked-list transfers.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dcs_pkg::*;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_NEXT  = 1'b1;

  localparam logic [2:0] CH_MDEC_IN  = 3'd0;
  localparam logic [2:0] CH_MDEC_OUT = 3'd1;
  localparam logic [2:0] CH_SPU      = 3'd4;
  localparam logic [2:0] CH_PIO      = 3'd5;
  localparam logic [2:0] CH_BAD      = 3'd7;

  localparam logic [ADDRESS_BITS-1:0] ADDR_MASK = 21'h1F_FFFC;
  localparam int DRAIN_CYCLES = 4;
  localparam int STALL_LIMIT  = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic func = 1'b0;
  logic [2:0] channel = '0;
  logic [WORD_BITS-1:0] word_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  kind_t kind;
  logic [ADDRESS_BITS-1:0] ram_address;
  logic [WORD_BITS-1:0] word_out;
  logic irq;
  logic last;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  dma_channel_sequencer dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Register copies and channel state of the predictor.
  logic [ADDRESS_BITS-1:0] reg_base = '0;
  logic [COUNT_BITS-1:0]   reg_count = '0;
  logic                    reg_to_ram = 1'b0;
  logic                    reg_back = 1'b0;
  logic                    reg_list = 1'b0;
  logic [6:0]              reg_mask = '0;
  logic                    reg_master = 1'b0;

  logic                    chan_busy = 1'b0;
  phase_t                  phase_now = PH_IDLE;
  logic [2:0]              run_channel = '0;
  logic [ADDRESS_BITS-1:0] cur_addr = '0;
  logic [COUNT_BITS-1:0]   words_to_go = '0;
  logic [7:0]              pkt_to_go = '0;
  logic [23:0]             pkt_link = '0;
  logic [6:0]              done_flags = '0;

  res_t due_ops[$];

  bit quiet = 1'b0;
  int unsigned items_done = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned blocks_started = 0;
  int unsigned walks_started = 0;
  int unsigned transfers_closed = 0;
  int unsigned errors_flagged = 0;
  int unsigned idle_cycles = 0;

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
  endtask

  task automatic owe(input kind_t k, input logic [ADDRESS_BITS-1:0] a,
                     input logic [WORD_BITS-1:0] w, input logic i, input logic l);
    res_t r;
    r.kind = k;
    r.addr = a;
    r.word = w;
    r.irq = i;
    r.last = l;
    due_ops.push_back(r);
    if (k == K_DONE) transfers_closed++;
    if (k == K_ERROR) errors_flagged++;
  endtask

  task automatic close_transfer();
    logic raise;
    raise = 1'b0;
    if (reg_mask[run_channel]) begin
      done_flags[run_channel] = 1'b1;
      raise = reg_master;
    end
    phase_now = PH_IDLE;
    chan_busy = 1'b0;
    owe(K_DONE, '0, '0, raise, 1'b1);
  endtask

  // After a header or packet word: read the next packet word, follow the link, or stop.
  task automatic follow_packet();
    if (pkt_to_go != 0) begin
      cur_addr = (cur_addr + 21'd4) & ADDR_MASK;
      phase_now = PH_DATA;
      owe(K_READ, cur_addr, '0, 1'b0, 1'b1);
    end else if (pkt_link[END_BIT]) begin
      close_transfer();
    end else begin
      cur_addr = pkt_link[ADDRESS_BITS-1:0] & ADDR_MASK;
      phase_now = PH_HDR;
      owe(K_READ, cur_addr, '0, 1'b0, 1'b1);
    end
  endtask

  task automatic advance_channel(input logic f, input logic [2:0] ch,
                                 input logic [WORD_BITS-1:0] w);
    logic [ADDRESS_BITS-1:0] a;
    logic [WORD_BITS-1:0] d;
    if (f == FUNC_START) begin
      phase_now = PH_IDLE;
      chan_busy = 1'b0;
      if (ch >= CHANNEL_COUNT || (reg_list && (ch != CH_GPU || reg_to_ram))) begin
        owe(K_ERROR, '0, '0, 1'b0, 1'b1);
      end else begin
        run_channel = ch;
        cur_addr = reg_base & ADDR_MASK;
        chan_busy = 1'b1;
        if (reg_list) begin
          walks_started++;
          phase_now = PH_HDR;
          owe(K_READ, cur_addr, '0, 1'b0, 1'b1);
        end else begin
          blocks_started++;
          words_to_go = reg_count;
          if (words_to_go == 0) begin
            close_transfer();
          end else begin
            phase_now = PH_BLOCK;
            if (!reg_to_ram) owe(K_READ, cur_addr, '0, 1'b0, 1'b1);
          end
        end
      end
    end else begin
      case (phase_now)
        PH_BLOCK: begin
          a = cur_addr;
          words_to_go = words_to_go - 1'b1;
          cur_addr = (reg_back ? a - 21'd4 : a + 21'd4) & ADDR_MASK;
          if (reg_to_ram) begin
            d = '0;
            // The ordering table holds back links, closed by an end marker.
            if (run_channel == CH_OTC)
              d = (words_to_go == 0) ? OTC_END : WORD_BITS'((a - 21'd4) & ADDR_MASK);
            else if (run_channel == CH_GPU || run_channel == CH_CDROM)
              d = w;
            owe(K_WRITE, a, d, 1'b0, words_to_go == 0);
            if (words_to_go == 0) close_transfer();
          end else begin
            if (run_channel == CH_GPU) owe(K_GPU, '0, w, 1'b0, 1'b0);
            if (words_to_go == 0) close_transfer();
            else owe(K_READ, cur_addr, '0, 1'b0, 1'b1);
          end
        end
        PH_HDR: begin
          pkt_to_go = w[31:24];
          pkt_link = w[23:0];
          follow_packet();
        end
        PH_DATA: begin
          owe(K_GPU, '0, w, 1'b0, 1'b0);
          pkt_to_go = pkt_to_go - 1'b1;
          follow_packet();
        end
        default: ;
      endcase
    end
  endtask

  task automatic send_item(input logic f, input logic [2:0] ch,
                           input logic [WORD_BITS-1:0] w);
    in_valid <= 1'b1;
    func <= f;
    channel <= ch;
    word_in <= w;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (!(f == FUNC_NEXT && phase_now == PH_IDLE)) items_done++;
    advance_channel(f, ch, w);
    if (!quiet && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Lets every owed result arrive, then waits out a drain period for transactions that owe none.
  task automatic settle();
    in_valid <= 1'b0;
    while (due_ops.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input cfg_reg_t r, input logic [CFG_DATA_BITS-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (r)
      REG_BASE_ADDRESS:  reg_base = v[ADDRESS_BITS-1:0];
      REG_WORD_COUNT:    reg_count = v;
      REG_TOWARD_RAM:    reg_to_ram = v[0];
      REG_STEP_BACKWARD: reg_back = v[0];
      REG_LINKED_LIST:   reg_list = v[0];
      REG_IRQ_MASK:      reg_mask = v[6:0];
      REG_IRQ_MASTER:    reg_master = v[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_regs(input logic [ADDRESS_BITS-1:0] base,
                           input logic [COUNT_BITS-1:0] count, input logic to_ram,
                           input logic back, input logic list, input logic [6:0] mask,
                           input logic master);
    set_reg(REG_BASE_ADDRESS, CFG_DATA_BITS'(base));
    set_reg(REG_WORD_COUNT, count);
    set_reg(REG_TOWARD_RAM, CFG_DATA_BITS'(to_ram));
    set_reg(REG_STEP_BACKWARD, CFG_DATA_BITS'(back));
    set_reg(REG_LINKED_LIST, CFG_DATA_BITS'(list));
    set_reg(REG_IRQ_MASK, CFG_DATA_BITS'(mask));
    set_reg(REG_IRQ_MASTER, CFG_DATA_BITS'(master));
  endtask

  function automatic logic [ADDRESS_BITS-1:0] pick_base();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return ADDRESS_BITS'($urandom());
    endcase
  endfunction

  task automatic test_block_to_ram();
    settle();
    // The top address steps forward and wraps to zero.
    load_regs('1, 24'd3, 1'b1, 1'b0, 1'b0, 7'h7F, 1'b1);
    send_item(FUNC_START, CH_OTC, '0);
    send_item(FUNC_NEXT, CH_BAD, 32'hFFFF_FFFF);
    send_item(FUNC_NEXT, CH_MDEC_IN, 32'h0000_0000);
    send_item(FUNC_NEXT, CH_OTC, 32'hA5A5_A5A5);
    settle();
    load_regs('0, 24'd2, 1'b1, 1'b1, 1'b0, 7'h04, 1'b1);
    send_item(FUNC_START, CH_GPU, '1);
    send_item(FUNC_NEXT, CH_GPU, 32'hFFFF_FFFF);
    send_item(FUNC_NEXT, CH_GPU, 32'h0000_0000);
  endtask

  task automatic test_block_from_ram();
    settle();
    load_regs(21'h000100, 24'd2, 1'b0, 1'b0, 1'b0, 7'h00, 1'b1);
    send_item(FUNC_START, CH_GPU, '0);
    send_item(FUNC_NEXT, CH_GPU, 32'h1234_5678);
    send_item(FUNC_NEXT, CH_GPU, 32'h8765_4321);
    send_item(FUNC_START, CH_SPU, '0);
    send_item(FUNC_NEXT, CH_SPU, 32'hDEAD_BEEF);
    send_item(FUNC_NEXT, CH_SPU, 32'hCAFE_F00D);
  endtask

  task automatic test_special_cases();
    settle();
    load_regs(21'h000040, 24'd0, 1'b0, 1'b0, 1'b0, 7'h7F, 1'b0);
    send_item(FUNC_START, CH_MDEC_IN, '0);
    send_item(FUNC_START, CH_BAD, '0);
    send_item(FUNC_NEXT, CH_PIO, 32'h5555_AAAA);
    settle();
    // A maximal count keeps the channel busy until a new start drops it.
    load_regs(21'h000080, '1, 1'b0, 1'b0, 1'b0, 7'h08, 1'b1);
    send_item(FUNC_START, CH_CDROM, '0);
    send_item(FUNC_NEXT, CH_CDROM, 32'h0F0F_0F0F);
    send_item(FUNC_START, CH_PIO, '0);
    send_item(FUNC_NEXT, CH_PIO, 32'hF0F0_F0F0);
  endtask

  task automatic test_linked_list();
    settle();
    load_regs(21'h001000, 24'd0, 1'b0, 1'b0, 1'b1, 7'h04, 1'b1);
    send_item(FUNC_START, CH_GPU, '0);
    send_item(FUNC_NEXT, CH_GPU, {8'd1, 24'h002000});
    send_item(FUNC_NEXT, CH_GPU, 32'h0102_0304);
    send_item(FUNC_NEXT, CH_GPU, {8'd0, 24'h800000});
    send_item(FUNC_START, CH_MDEC_OUT, '0);
    settle();
    set_reg(REG_TOWARD_RAM, 24'd1);
    send_item(FUNC_START, CH_GPU, '0);
  endtask

  task automatic test_random_blocks();
    logic [COUNT_BITS-1:0] count;
    logic [2:0] ch;
    int unsigned n;
    while (items_done < 1100) begin
      settle();
      quiet = (items_done >= 400 && items_done < 700);
      case ($urandom_range(29))
        0, 1: count = '0;
        2: count = '1;
        3, 4, 5: count = COUNT_BITS'($urandom_range(9, 24));
        default: count = COUNT_BITS'($urandom_range(1, 8));
      endcase
      load_regs(pick_base(), count, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0,
                7'($urandom_range(127)), 1'($urandom_range(1)));
      repeat ($urandom_range(1, 4)) begin
        ch = ($urandom_range(19) == 0) ? CH_BAD : 3'($urandom_range(CHANNEL_COUNT - 1));
        if (ch == CH_BAD) n = 0;
        else if (reg_count > 24'd64) n = $urandom_range(3);
        else n = reg_count;
        if (n != 0 && $urandom_range(9) == 0) n = $urandom_range(n - 1);
        send_item(FUNC_START, ch, $urandom());
        repeat (n) send_item(FUNC_NEXT, 3'($urandom_range(7)), $urandom());
        if ($urandom_range(11) == 0) send_item(FUNC_NEXT, 3'($urandom_range(7)), $urandom());
      end
    end
    quiet = 1'b0;
  endtask

  task automatic test_random_lists();
    logic [7:0] cnt;
    logic [WORD_BITS-1:0] hdr;
    logic [2:0] ch;
    int unsigned packets;
    while (items_done < 1850) begin
      settle();
      load_regs(pick_base(), COUNT_BITS'($urandom()), $urandom_range(9) == 0,
                1'($urandom_range(1)), 1'b1, 7'($urandom_range(127)),
                1'($urandom_range(1)));
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(9) == 0) begin
          do ch = 3'($urandom_range(7)); while (ch == CH_GPU);
          send_item(FUNC_START, ch, $urandom());
        end else begin
          send_item(FUNC_START, CH_GPU, $urandom());
          if (!reg_to_ram) begin
            packets = $urandom_range(1, 4);
            for (int p = 0; p < packets; p++) begin
              cnt = ($urandom_range(59) == 0) ? 8'hFF : 8'($urandom_range(4));
              hdr = $urandom();
              hdr[31:24] = cnt;
              // Mostly the end mark sits on the last packet only; sometimes it is random.
              hdr[END_BIT] = ($urandom_range(7) == 0) ? 1'($urandom_range(1))
                                                      : (p == packets - 1);
              if ($urandom_range(24) == 0) break;
              send_item(FUNC_NEXT, 3'($urandom_range(7)), hdr);
              repeat (cnt) send_item(FUNC_NEXT, 3'($urandom_range(7)), $urandom());
            end
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 6);
  end

  // Compares each result transaction with the oldest prediction.
  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_seen++;
      if (due_ops.size() == 0) begin
        flag_mismatch("result with nothing expected, kind", kind, '0);
      end else begin
        want = due_ops.pop_front();
        if (kind !== want.kind) flag_mismatch("kind", kind, want.kind);
        if (ram_address !== want.addr) flag_mismatch("ram_address", ram_address, want.addr);
        if (word_out !== want.word) flag_mismatch("word_out", word_out, want.word);
        if (irq !== want.irq) flag_mismatch("irq", irq, want.irq);
        if (last !== want.last) flag_mismatch("last", last, want.last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("Timed out after %0d cycles without a transaction.", STALL_LIMIT);
      $display("dma_channel_sequencer: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_block_to_ram();
    test_block_from_ram();
    test_special_cases();
    test_linked_list();
    test_random_blocks();
    test_random_lists();
    settle();
    repeat (8) @(posedge clk);
    if (due_ops.size() != 0)
      flag_mismatch("results never delivered", due_ops.size(), '0);
    if (done_flags !== dut.channel_flags)
      flag_mismatch("channel flags", 32'(dut.channel_flags), 32'(done_flags));
    $display("Sent %0d transactions and checked %0d results: %0d block starts, %0d list walks.",
             items_done, results_seen, blocks_started, walks_started);
    $display("Transfers completed: %0d, error results: %0d, mismatches: %0d.",
             transfers_closed, errors_flagged, mismatches);
    if (mismatches == 0)
      $display("dma_channel_sequencer: match");
    else
      $display("dma_channel_sequencer: mismatch");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/dcs_pkg.sv
hdl/dma_channel_sequencer.sv
verif/testbench.sv
